// ===== design/lightmap_texel_blend_defines.svh =====
// Assertion macros for the lightmap texel blend block.
// Included by the top level; depends on i_clk and i_rst_n being in scope.
`ifndef LIGHTMAP_TEXEL_BLEND_DEFINES_SVH
`define LIGHTMAP_TEXEL_BLEND_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset
`define LTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define LTB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define LTB_ASSERT(label, prop, msg)
`define LTB_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== design/ltb_pkg.sv =====
// Shared types and constants for the lightmap texel blend block.
// No dependencies.
`default_nettype none

package ltb_pkg;

    // Table geometry
    localparam int PALETTE_DEPTH     = 256;
    localparam int LIGHTMAP_DEPTH_DF = 512;

    // Queue depths (powers of two)
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // Request / command codes
    localparam logic [1:0] REQ_BLEND  = 2'd0;
    localparam logic [1:0] REQ_PAL_WR = 2'd1;
    localparam logic [1:0] REQ_LM_WR  = 2'd2;

    // Configuration register indexes
    localparam logic REG_SOLID    = 1'b0;
    localparam logic REG_XOR_MASK = 1'b1;

    typedef struct packed {
        logic [31:0] solid;
        logic [63:0] xor_mask;
    } t_cfg;

    // Classified command passed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] texel;
        logic [7:0]  tidx;
        logic [7:0]  lidx;
        logic [8:0]  addr;
        logic [63:0] data;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/ltb_fifo.sv =====
// Small register-based FIFO used for the command and result queues.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module ltb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int Cw = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [Aw-1:0]    r_wptr, r_rptr;
    logic [Cw-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == Cw'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + Aw'(1);
            if (do_pop)  r_rptr <= r_rptr + Aw'(1);
            r_count <= r_count + Cw'(do_push) - Cw'(do_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_data;
    end

endmodule

`default_nettype wire

// ===== design/ltb_front.sv =====
// Front end: accepts requests, drops ones that do nothing, queues commands.
// Depends on ltb_pkg and ltb_fifo.
`default_nettype none

module ltb_front
    import ltb_pkg::*;
#(
    parameter int LIGHTMAP_DEPTH = LIGHTMAP_DEPTH_DF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_texel,
    input  wire logic [7:0]  i_texture_index,
    input  wire logic [7:0]  i_lightmap_index,
    input  wire logic [8:0]  i_entry_address,
    input  wire logic [63:0] i_entry_data,
    input  wire logic        i_cmd_pop,
    output t_cmd             o_cmd,
    output logic             o_cmd_empty
);

    logic keep;
    logic cmd_push;
    t_cmd cmd;

    // Classify: out-of-range writes and unknown requests never reach the back end
    always_comb begin
        case (i_req_type)
            REQ_BLEND:  keep = 1'b1;
            REQ_PAL_WR: keep = (32'(i_entry_address) < 32'(PALETTE_DEPTH));
            REQ_LM_WR:  keep = (32'(i_entry_address) < 32'(LIGHTMAP_DEPTH));
            default:    keep = 1'b0;
        endcase
    end

    assign cmd_push = i_push && !o_full && keep;

    assign cmd.op    = i_req_type;
    assign cmd.texel = i_texel;
    assign cmd.tidx  = i_texture_index;
    assign cmd.lidx  = i_lightmap_index;
    assign cmd.addr  = i_entry_address;
    assign cmd.data  = i_entry_data;

    // Command queue between front and back
    ltb_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_full  (o_full),
        .o_empty (o_cmd_empty)
    );

endmodule

`default_nettype wire

// ===== design/ltb_back.sv =====
// Back end: table writes, table reads and the blend arithmetic pipeline.
// Depends on ltb_pkg.
`default_nettype none

module ltb_back
    import ltb_pkg::*;
#(
    parameter int LIGHTMAP_DEPTH = LIGHTMAP_DEPTH_DF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cmd_empty,
    output logic             o_cmd_pop,
    input  wire logic        i_out_pop,
    output logic             o_out_push,
    output logic [31:0]      o_out_pixel
);

    localparam int LmAw = $clog2(LIGHTMAP_DEPTH);
    localparam int Crw  = $clog2(OUT_DEPTH + 1);

    // Tables
    logic [31:0] r_pal_mem [PALETTE_DEPTH];
    logic [63:0] r_lm_mem  [LIGHTMAP_DEPTH];

    logic [Crw-1:0] r_credit;
    logic           credit_ok;
    logic           issue_blend;
    logic [LmAw-1:0] lm_rd_idx;

    // Stage 1: table read data
    logic        r_s1_valid;
    logic [31:0] r_s1_texel;
    logic [31:0] r_pal_rd;
    logic [63:0] r_lm_rd;

    // Stage 2: texel * palette byte products
    logic        r_s2_valid;
    logic [15:0] r_s2_a [4];
    logic [63:0] r_s2_lm;
    logic [63:0] r_s2_lx;
    logic [15:0] s1_a [4];

    // Stage 3: high halves
    logic        r_s3_valid;
    logic [15:0] r_s3_h1 [4];
    logic [15:0] r_s3_h2 [4];
    logic signed [31:0] s2_p1 [4];
    logic signed [31:0] s2_p2 [4];
    logic [15:0] s2_sb [4];

    logic [15:0] s3_sum [4];

    // Issue control: a blend only leaves the queue when the result queue has room
    assign credit_ok   = (r_credit < Crw'(OUT_DEPTH));
    assign o_cmd_pop   = !i_cmd_empty && credit_ok;
    assign issue_blend = o_cmd_pop && (i_cmd.op == REQ_BLEND);
    assign lm_rd_idx   = LmAw'(i_cmd.lidx) + LmAw'(i_cmd.tidx[7:1]);

    // Outstanding results: in the pipe or waiting in the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + Crw'(issue_blend) - Crw'(i_out_pop);
        end
    end

    // Table writes and reads, in command order
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            case (i_cmd.op)
                REQ_PAL_WR: r_pal_mem[i_cmd.addr[7:0]] <= i_cmd.data[31:0];
                REQ_LM_WR:  r_lm_mem[LmAw'(i_cmd.addr)] <= i_cmd.data;
                REQ_BLEND: begin
                    r_pal_rd   <= r_pal_mem[i_cmd.tidx];
                    r_lm_rd    <= r_lm_mem[lm_rd_idx];
                    r_s1_texel <= i_cmd.texel;
                end
                default: ;
            endcase
        end
    end

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue_blend;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Stage 1 -> 2: 8x8 products and masked lightmap
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s1_a[c] = 16'(r_s1_texel[c*8 +: 8]) * 16'(r_pal_rd[c*8 +: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) r_s2_a[c] <= s1_a[c];
        r_s2_lm <= r_lm_rd;
        r_s2_lx <= r_lm_rd ^ i_cfg.xor_mask;
    end

    // Stage 2 -> 3: signed 16x16 multiplies, keep the high halves
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s2_sb[c] = {2'b00, i_cfg.solid[c*8 +: 8], 6'b000000};
            s2_p1[c] = 32'($signed(r_s2_a[c])) * 32'($signed(r_s2_lx[c*16 +: 16]));
            s2_p2[c] = 32'($signed(s2_sb[c])) * 32'($signed(r_s2_lm[c*16 +: 16]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_s3_h1[c] <= s2_p1[c][31:16];
            r_s3_h2[c] <= s2_p2[c][31:16];
        end
    end

    // Stage 3: wrap-add, shift, saturate
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s3_sum[c] = r_s3_h1[c] + r_s3_h2[c];
            o_out_pixel[c*8 +: 8] = (s3_sum[c][15:12] != 4'd0) ? 8'hFF : s3_sum[c][11:4];
        end
    end

    assign o_out_push = r_s3_valid;

endmodule

`default_nettype wire

// ===== design/lightmap_texel_blend.sv =====
// Lightmap texel blend: top level with configuration registers and result queue.
// Depends on ltb_pkg, ltb_fifo, ltb_front, ltb_back and the defines header.
//
// Usage:
//   Requests enter through a queue-style port: a transaction is taken when push
//   is high and full is low. Blend requests produce one pixel each; palette and
//   lightmap load requests, out-of-range loads and unknown requests produce none.
//   Results leave through a queue-style port: o_out_pixel holds the oldest pixel
//   while empty is low, and pop with empty low takes it.
//   A blend request passes the command queue, table read, 8x8 multiply, 16x16
//   multiply and result queue. Throughput: one request per cycle while full is
//   low, set by the single table port per cycle.
//   When the receiver stalls, up to 8 results build up in the result queue;
//   requests then wait in the 4-entry command queue and full rises once it fills.
//   Loads are applied in request order, so a blend sees every earlier load.
//   Reset (synchronous, active low) empties both queues and clears the
//   configuration registers; table contents are undefined until loaded.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
//   (0 solid color, low 32 bits; 1 lightmap XOR mask) in that cycle.
`default_nettype none

`include "lightmap_texel_blend_defines.svh"

module lightmap_texel_blend
    import ltb_pkg::*;
#(
    parameter int LIGHTMAP_DEPTH = LIGHTMAP_DEPTH_DF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_texel,
    input  wire logic [7:0]  i_texture_index,
    input  wire logic [7:0]  i_lightmap_index,
    input  wire logic [8:0]  i_entry_address,
    input  wire logic [63:0] i_entry_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_out_pixel
);

    t_cfg        r_cfg;
    t_cmd        cmd;
    logic        cmd_empty;
    logic        cmd_pop;
    logic        out_push;
    logic        out_full;
    logic        out_pop;
    logic [31:0] out_pixel;
    logic        solid_we;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOLID:    r_cfg.solid    <= i_cfg_wdata[31:0];
                REG_XOR_MASK: r_cfg.xor_mask <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign solid_we = i_cfg_we && (i_cfg_index == REG_SOLID);

    ltb_front #(
        .LIGHTMAP_DEPTH (LIGHTMAP_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_req_type       (i_req_type),
        .i_texel          (i_texel),
        .i_texture_index  (i_texture_index),
        .i_lightmap_index (i_lightmap_index),
        .i_entry_address  (i_entry_address),
        .i_entry_data     (i_entry_data),
        .i_cmd_pop        (cmd_pop),
        .o_cmd            (cmd),
        .o_cmd_empty      (cmd_empty)
    );

    assign out_pop = pop && !empty;

    ltb_back #(
        .LIGHTMAP_DEPTH (LIGHTMAP_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_pop   (out_pop),
        .o_out_push  (out_push),
        .o_out_pixel (out_pixel)
    );

    // Result queue
    ltb_fifo #(
        .WIDTH (32),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_pixel),
        .i_pop   (pop),
        .o_data  (o_out_pixel),
        .o_full  (out_full),
        .o_empty (empty)
    );

    // Checks
    `LTB_ASSERT(a_out_no_overflow, out_push |-> !out_full, "result pushed into full queue")
    `LTB_ASSERT(a_cmd_pop_nonempty, cmd_pop |-> !cmd_empty, "command popped from empty queue")
    `LTB_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> empty && !out_push, "not empty after reset")
    `LTB_ASSERT(a_cfg_solid, solid_we |=> r_cfg.solid == $past(i_cfg_wdata[31:0]), "solid lost")

endmodule

`default_nettype wire

// ===== sim/lightmap_texel_blend_tb.sv =====
// Testbench for lightmap_texel_blend: random and directed requests, scoreboard check.
// Depends on ltb_pkg and the lightmap_texel_blend RTL.
`timescale 1ns / 1ps

module lightmap_texel_blend_tb;
    import ltb_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 170;
    localparam int PHASE_COUNT   = 8;
    localparam int LM_READ_TOP   = 255 + 127;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] texel;
        logic [7:0]  tex_idx;
        logic [7:0]  lm_idx;
        logic [8:0]  addr;
        logic [63:0] data;
    } t_blend_req;

    // Tracks table and register state, predicts pixels, checks them in order
    class blend_scoreboard;
        logic [31:0] palette [PALETTE_DEPTH];
        logic [63:0] lightmap [LIGHTMAP_DEPTH_DF];
        logic [31:0] solid;
        logic [63:0] xor_mask;
        logic [31:0] expected_pixels [$];
        int errors;

        function new();
            solid    = '0;
            xor_mask = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic idx, logic [63:0] value);
            if (idx == REG_SOLID)
                solid = value[31:0];
            else
                xor_mask = value;
        endfunction

        function logic [31:0] blend_pixel(t_blend_req r);
            logic [31:0] pal;
            logic [31:0] res;
            logic [63:0] lm;
            logic [63:0] lx;
            logic [8:0] li;
            logic signed [15:0] a_lane;
            logic signed [15:0] lx_lane;
            logic signed [15:0] s_lane;
            logic signed [15:0] lm_lane;
            logic signed [31:0] p1;
            logic signed [31:0] p2;
            logic [15:0] sum;
            logic [11:0] v;
            pal = palette[r.tex_idx];
            li  = {1'b0, r.lm_idx} + {2'b00, r.tex_idx[7:1]};
            lm  = (li < LIGHTMAP_DEPTH_DF) ? lightmap[li] : '0;
            lx  = lm ^ xor_mask;
            res = '0;
            for (int c = 0; c < 4; c++) begin
                a_lane  = 16'(r.texel[8*c +: 8]) * 16'(pal[8*c +: 8]);
                lx_lane = lx[16*c +: 16];
                s_lane  = {2'b00, solid[8*c +: 8], 6'b000000};
                lm_lane = lm[16*c +: 16];
                p1 = 32'(a_lane) * 32'(lx_lane);
                p2 = 32'(s_lane) * 32'(lm_lane);
                // 16-bit wrap, then unsigned shift and clamp
                sum = p1[31:16] + p2[31:16];
                v   = sum[15:4];
                res[8*c +: 8] = (v > 12'd255) ? 8'hff : v[7:0];
            end
            return res;
        endfunction

        function void note_request(t_blend_req r);
            case (r.kind)
                REQ_BLEND:  expected_pixels.push_back(blend_pixel(r));
                REQ_PAL_WR: if (r.addr < PALETTE_DEPTH) palette[r.addr[7:0]] = r.data[31:0];
                REQ_LM_WR:  if (r.addr < LIGHTMAP_DEPTH_DF) lightmap[r.addr] = r.data;
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [31:0] got);
            logic [31:0] want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    $display("%0t: out_pixel mismatch, expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = REG_SOLID;
    logic [63:0] i_cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_req_type = REQ_BLEND;
    logic [31:0] i_texel = '0;
    logic [7:0]  i_texture_index = '0;
    logic [7:0]  i_lightmap_index = '0;
    logic [8:0]  i_entry_address = '0;
    logic [63:0] i_entry_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_out_pixel;

    blend_scoreboard sb = new();
    bit no_idle = 1'b0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int cycle_count = 0;

    lightmap_texel_blend dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_texel          (i_texel),
        .i_texture_index  (i_texture_index),
        .i_lightmap_index (i_lightmap_index),
        .i_entry_address  (i_entry_address),
        .i_entry_data     (i_entry_data),
        .empty            (empty),
        .pop              (pop),
        .o_out_pixel      (o_out_pixel)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: check each popped pixel, random pops, long hold-offs on request
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_pixel(o_out_pixel);
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_hold_left > 0) begin
            pop <= 1'b0;
            rx_hold_left--;
        end else begin
            pop <= no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    // Lane values that hit the signed corners
    function automatic logic [15:0] biased_lane();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h7fff;
            2: return 16'h8000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] biased_lm();
        return {biased_lane(), biased_lane(), biased_lane(), biased_lane()};
    endfunction

    function automatic logic [31:0] biased_bytes();
        logic [31:0] w;
        w = $urandom;
        for (int c = 0; c < 4; c++) begin
            case ($urandom_range(0, 5))
                0: w[8*c +: 8] = 8'h00;
                1: w[8*c +: 8] = 8'hff;
                default: ;
            endcase
        end
        return w;
    endfunction

    function automatic t_blend_req make_req(logic [1:0] kind, logic [31:0] texel,
                                            logic [7:0] tex_idx, logic [7:0] lm_idx,
                                            logic [8:0] addr, logic [63:0] data);
        t_blend_req r;
        r.kind    = kind;
        r.texel   = texel;
        r.tex_idx = tex_idx;
        r.lm_idx  = lm_idx;
        r.addr    = addr;
        r.data    = data;
        return r;
    endfunction

    // Mostly blends over loaded tables, with loads and unknown requests mixed in
    function automatic t_blend_req random_req();
        t_blend_req r;
        int sel;
        r = make_req(REQ_BLEND, biased_bytes(), 8'($urandom), 8'($urandom),
                     9'($urandom_range(0, 511)), {$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            r.kind = REQ_BLEND;
        end else if (sel < 75) begin
            r.kind = REQ_PAL_WR;
            r.data = {$urandom, biased_bytes()};
        end else if (sel < 95) begin
            r.kind = REQ_LM_WR;
            r.data = biased_lm();
        end else begin
            r.kind = REQ_UNKNOWN;
        end
        return r;
    endfunction

    // Offer one request and wait for the transaction
    task automatic send_req(t_blend_req r);
        while (!no_idle && $urandom_range(0, 99) < 32) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_req_type       <= r.kind;
        i_texel          <= r.texel;
        i_texture_index  <= r.tex_idx;
        i_lightmap_index <= r.lm_idx;
        i_entry_address  <= r.addr;
        i_entry_data     <= r.data;
        do
            @(posedge i_clk);
        while (full);
        sb.note_request(r);
    endtask

    // Stop sending until all pixels are back, then let queued loads settle
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; block must be idle
    task automatic set_config(logic [63:0] solid_word, logic [63:0] mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SOLID;
        i_cfg_wdata <= solid_word;
        @(posedge i_clk);
        sb.write_reg(REG_SOLID, solid_word);
        i_cfg_index <= REG_XOR_MASK;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        sb.write_reg(REG_XOR_MASK, mask);
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_blends();
        send_req(make_req(REQ_BLEND, 32'hffffffff, 8'd0, 8'd0, 9'd0, '0));
        send_req(make_req(REQ_BLEND, 32'h00000000, 8'd0, 8'd0, 9'd511, '1));
        send_req(make_req(REQ_BLEND, 32'hffffffff, 8'd255, 8'd255, 9'd0, '0));
        send_req(make_req(REQ_BLEND, 32'h00000000, 8'd255, 8'd255, 9'd511, '1));
    endtask

    // Main sequence
    initial begin
        logic [63:0] solid_word;
        logic [63:0] mask;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table extremes, ignored out-of-range palette loads, unknown request
        send_req(make_req(REQ_PAL_WR, '0, '0, '0, 9'd0, 64'hffffffff_01010101));
        send_req(make_req(REQ_PAL_WR, '0, '0, '0, 9'd255, 64'h00000000_ffffffff));
        send_req(make_req(REQ_PAL_WR, '0, '0, '0, 9'd256, {$urandom, $urandom}));
        send_req(make_req(REQ_PAL_WR, '0, '0, '0, 9'd511, {$urandom, $urandom}));
        send_req(make_req(REQ_LM_WR, '0, '0, '0, 9'd0, 64'h80008000_80008000));
        send_req(make_req(REQ_LM_WR, '0, '0, '0, 9'(LM_READ_TOP), 64'h7fff7fff_7fff7fff));
        send_req(make_req(REQ_LM_WR, '0, '0, '0, 9'd511, '1));
        // Reset config: negative sums saturate, zero texel gives zero
        directed_blends();
        send_req(make_req(REQ_UNKNOWN, $urandom, 8'($urandom), 8'($urandom),
                          9'($urandom), '1));
        drain();
        set_config({$urandom, 32'hffffffff}, '1);
        directed_blends();

        // Load every entry a blend can read
        for (int i = 0; i < PALETTE_DEPTH; i++)
            send_req(make_req(REQ_PAL_WR, $urandom, 8'($urandom), 8'($urandom), 9'(i),
                              {$urandom, biased_bytes()}));
        for (int i = 0; i <= LM_READ_TOP; i++)
            send_req(make_req(REQ_LM_WR, $urandom, 8'($urandom), 8'($urandom), 9'(i),
                              biased_lm()));

        // Random phases under different register settings
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            case (p)
                0: begin solid_word = '0; mask = '0; end
                1: begin solid_word = '1; mask = '1; end
                2: begin solid_word = {$urandom, 32'hffffffff}; mask = '0; end
                3: begin solid_word = {$urandom, 32'h00000000}; mask = '1; end
                default: begin
                    solid_word = {$urandom, biased_bytes()};
                    mask = {$urandom, $urandom};
                end
            endcase
            set_config(solid_word, mask);
            no_idle = (p == 4);
            if (p == 2 || p == 6)
                rx_hold_req = 400;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_req(random_req());
        end
        no_idle = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== lightmap_texel_blend.f =====
+incdir+design
design/ltb_pkg.sv
design/ltb_fifo.sv
design/ltb_front.sv
design/ltb_back.sv
design/lightmap_texel_blend.sv
sim/lightmap_texel_blend_tb.sv
